>>> src/ndrd_pkg.sv
`default_nettype none

package ndrd_pkg;

	// Field widths
	localparam int BYTE_W      = 8;
	localparam int SPC_W       = 8;
	localparam int VOL_BASE_W  = 32;
	localparam int SECTOR_W    = 48;
	localparam int COUNT_W     = 40;
	localparam int ADDR_W      = 48;
	localparam int CLUSTERS_W  = 32;
	localparam int LEN_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 48;

	// Parameter defaults
	localparam int MAX_FIELD_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH_DEF     = 4;

	// Register reset values
	localparam logic [SPC_W-1:0]      SPC_RESET      = 8'd8;
	localparam logic [VOL_BASE_W-1:0] VOL_BASE_RESET = 32'd0;
	localparam logic [ADDR_W-1:0]     DEST_RESET     = 48'h0000_0020_0000;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SPC      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOL_BASE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEST     = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_RUN       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_END       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] run_byte;
		logic              list_start;
	} run_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SECTOR_W-1:0] start_sector;
		logic [COUNT_W-1:0]  sector_count;
		logic [ADDR_W-1:0]   dest_address;
	} run_out_t;

	// One classified item handed from the parser to the run unit
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic                  reload;
		logic [CLUSTERS_W-1:0] clusters;
		logic [SECTOR_W-1:0]   offset;
		logic [SECTOR_W-1:0]   base;
		logic [ADDR_W-1:0]     dest;
	} job_t;

endpackage

`default_nettype wire

>>> src/ndrd_front.sv
`default_nettype none

module ndrd_front #(
	parameter int MAX_FIELD_BYTES = ndrd_pkg::MAX_FIELD_BYTES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire ndrd_pkg::run_in_t                    in_data,
	input  wire logic [ndrd_pkg::VOL_BASE_W-1:0]      vol_base,
	input  wire logic [ndrd_pkg::ADDR_W-1:0]          dest_base,
	output logic                                      push_valid,
	output ndrd_pkg::job_t                            push_job,
	input  wire logic                                 queue_full
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_COUNT  = 2'd1;
	localparam logic [1:0] PH_OFFSET = 2'd2;
	localparam logic [1:0] PH_IDLE   = 2'd3;

	localparam logic [ndrd_pkg::LEN_W-1:0] MAX_LEN = ndrd_pkg::LEN_W'(MAX_FIELD_BYTES);

	// Sign-extend an offset of len bytes into the sector width
	function automatic logic [ndrd_pkg::SECTOR_W-1:0] ext_offset(
		input logic [ndrd_pkg::SECTOR_W-1:0] acc,
		input logic [ndrd_pkg::LEN_W-1:0]    len
	);
		logic [ndrd_pkg::SECTOR_W-1:0] r;
		r = acc;
		case (len)
			4'd0: r = '0;
			4'd1: r = {{40{acc[7]}}, acc[7:0]};
			4'd2: r = {{32{acc[15]}}, acc[15:0]};
			4'd3: r = {{24{acc[23]}}, acc[23:0]};
			4'd4: r = {{16{acc[31]}}, acc[31:0]};
			4'd5: r = {{8{acc[39]}}, acc[39:0]};
			default: r = acc;
		endcase
		return r;
	endfunction

	logic [1:0]                              phase_q, phase_d;
	logic [ndrd_pkg::LEN_W-1:0]              cnt_len_q, cnt_len_d;
	logic [ndrd_pkg::LEN_W-1:0]              off_len_q, off_len_d;
	logic [ndrd_pkg::LEN_W-1:0]              idx_q, idx_d;
	logic [ndrd_pkg::CLUSTERS_W-1:0]         cnt_acc_q, cnt_acc_d;
	logic [ndrd_pkg::SECTOR_W-1:0]           off_acc_q, off_acc_d;
	logic                                    reload_q;
	logic [ndrd_pkg::SECTOR_W-1:0]           rl_base_q;
	logic [ndrd_pkg::ADDR_W-1:0]             rl_dest_q;

	logic                                    accept;
	logic [1:0]                              eff_phase;
	logic [ndrd_pkg::LEN_W-1:0]              eff_idx, idx_inc;
	logic [ndrd_pkg::LEN_W-1:0]              hdr_cl, hdr_ol;
	logic [ndrd_pkg::BYTE_W-1:0]             b;
	logic                                    emit;
	logic [ndrd_pkg::STATUS_W-1:0]           emit_status;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// Classify the byte and work out the next parser state
	always_comb begin
		b         = in_data.run_byte;
		eff_phase = in_data.list_start ? PH_HEADER : phase_q;
		eff_idx   = in_data.list_start ? '0 : idx_q;
		idx_inc   = eff_idx + 4'd1;
		hdr_cl    = b[3:0];
		hdr_ol    = b[7:4];

		phase_d     = eff_phase;
		cnt_len_d   = cnt_len_q;
		off_len_d   = off_len_q;
		idx_d       = eff_idx;
		cnt_acc_d   = cnt_acc_q;
		off_acc_d   = off_acc_q;
		emit        = 1'b0;
		emit_status = ndrd_pkg::ST_RUN;

		case (eff_phase)
			PH_HEADER: begin
				if (b == '0) begin
					emit        = 1'b1;
					emit_status = ndrd_pkg::ST_END;
					phase_d     = PH_IDLE;
				end else if (hdr_cl > MAX_LEN || hdr_ol > MAX_LEN) begin
					emit        = 1'b1;
					emit_status = ndrd_pkg::ST_MALFORMED;
					phase_d     = PH_IDLE;
				end else begin
					cnt_len_d = hdr_cl;
					off_len_d = hdr_ol;
					cnt_acc_d = '0;
					off_acc_d = '0;
					idx_d     = '0;
					phase_d   = (hdr_cl != '0) ? PH_COUNT : PH_OFFSET;
				end
			end
			PH_COUNT: begin
				// Only the low four count bytes are kept
				for (int k = 0; k < 4; k++) begin
					if (eff_idx == ndrd_pkg::LEN_W'(k))
						cnt_acc_d[8*k +: 8] = b;
				end
				idx_d = idx_inc;
				if (idx_inc >= cnt_len_q) begin
					idx_d = '0;
					if (off_len_q == '0) begin
						emit    = 1'b1;
						phase_d = PH_HEADER;
					end else begin
						phase_d = PH_OFFSET;
					end
				end
			end
			PH_OFFSET: begin
				// Bytes above the sector width cannot reach the result
				for (int k = 0; k < 6; k++) begin
					if (eff_idx[2:0] == 3'(k))
						off_acc_d[8*k +: 8] = b;
				end
				idx_d = idx_inc;
				if (idx_inc >= off_len_q) begin
					idx_d   = '0;
					emit    = 1'b1;
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Build the job for the run unit
	always_comb begin
		push_valid        = accept && emit;
		push_job.status   = emit_status;
		push_job.reload   = reload_q || in_data.list_start;
		push_job.clusters = cnt_acc_d;
		push_job.offset   = ext_offset(off_acc_d, off_len_q);
		push_job.base     = in_data.list_start
			? ndrd_pkg::SECTOR_W'(vol_base) : rl_base_q;
		push_job.dest     = in_data.list_start ? dest_base : rl_dest_q;
	end

	// Advance parser control on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			cnt_len_q <= '0;
			off_len_q <= '0;
			idx_q     <= '0;
			reload_q  <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			cnt_len_q <= cnt_len_d;
			off_len_q <= off_len_d;
			idx_q     <= idx_d;
			if (emit)
				reload_q <= 1'b0;
			else if (in_data.list_start)
				reload_q <= 1'b1;
		end
	end

	// Hold accumulators and the captured list bases
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_acc_q <= cnt_acc_d;
			off_acc_q <= off_acc_d;
			if (in_data.list_start) begin
				rl_base_q <= ndrd_pkg::SECTOR_W'(vol_base);
				rl_dest_q <= dest_base;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/ndrd_fifo.sv
`default_nettype none

module ndrd_fifo #(
	parameter int DEPTH = ndrd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire ndrd_pkg::job_t push_job,
	output logic                full,
	output logic                pop_valid,
	output ndrd_pkg::job_t      pop_job,
	input  wire logic           pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	ndrd_pkg::job_t     slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

>>> src/ndrd_back.sv
`default_nettype none

module ndrd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [ndrd_pkg::SPC_W-1:0]     spc,
	input  wire logic                           job_valid,
	input  wire ndrd_pkg::job_t                 job,
	output logic                                job_pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output ndrd_pkg::run_out_t                  out_data
);

	logic                                   valid_s1;
	logic [ndrd_pkg::STATUS_W-1:0]          status_s1;
	logic                                   reload_s1;
	logic [ndrd_pkg::SECTOR_W-1:0]          base_s1;
	logic [ndrd_pkg::ADDR_W-1:0]            dest_s1;
	logic [ndrd_pkg::SECTOR_W-1:0]          off_prod_s1;
	logic [ndrd_pkg::COUNT_W-1:0]           cnt_prod_s1;

	logic                                   out_valid_q;
	ndrd_pkg::run_out_t                     out_q;
	logic [ndrd_pkg::SECTOR_W-1:0]          run_base_q;
	logic [ndrd_pkg::ADDR_W-1:0]            next_dest_q;

	logic                                   adv, load_s1;
	logic [ndrd_pkg::SECTOR_W-1:0]          cur_base, new_base;
	logic [ndrd_pkg::ADDR_W-1:0]            cur_dest, new_dest;

	assign adv       = !out_valid_q || !out_stall;
	assign load_s1   = !valid_s1 || adv;
	assign job_pop   = job_valid && load_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Stage 1: scale offset and cluster count by sectors per cluster
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= job_valid;
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			status_s1   <= job.status;
			reload_s1   <= job.reload;
			base_s1     <= job.base;
			dest_s1     <= job.dest;
			off_prod_s1 <= job.offset * ndrd_pkg::SECTOR_W'(spc);
			cnt_prod_s1 <= ndrd_pkg::COUNT_W'(job.clusters) * ndrd_pkg::COUNT_W'(spc);
		end
	end

	// Stage 2: add to the running bases
	always_comb begin
		cur_base = reload_s1 ? base_s1 : run_base_q;
		cur_dest = reload_s1 ? dest_s1 : next_dest_q;
		new_base = cur_base + off_prod_s1;
		new_dest = cur_dest + ndrd_pkg::ADDR_W'({cnt_prod_s1, 9'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_base_q  <= ndrd_pkg::SECTOR_W'(ndrd_pkg::VOL_BASE_RESET);
			next_dest_q <= ndrd_pkg::DEST_RESET;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				if (status_s1 == ndrd_pkg::ST_RUN) begin
					run_base_q  <= new_base;
					next_dest_q <= new_dest;
				end else begin
					run_base_q  <= cur_base;
					next_dest_q <= cur_dest;
				end
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q.status <= status_s1;
			if (status_s1 == ndrd_pkg::ST_RUN) begin
				out_q.start_sector <= new_base;
				out_q.sector_count <= cnt_prod_s1;
				out_q.dest_address <= cur_dest;
			end else begin
				out_q.start_sector <= '0;
				out_q.sector_count <= '0;
				out_q.dest_address <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/ntfs_data_run_decoder.sv
// Channel   Direction  Handshake               Carries
// in        in         in_valid / in_stall     run_in_t: run_byte, list_start
// out       out        out_valid / out_stall   run_out_t: status, sectors, address
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is taken per cycle; the parser stalls the input only when the job
// queue is full. A run, end or malformed result passes through the queue slot,
// the multiply stage and the output register before it is offered. Results
// sustain one per cycle while out_stall is low, through the single multiply and
// add stages of the run unit.
// Reset clears parser, queue and pipeline control and loads register defaults.
`default_nettype none

module ntfs_data_run_decoder #(
	parameter int MAX_FIELD_BYTES = ndrd_pkg::MAX_FIELD_BYTES_DEF,
	parameter int QUEUE_DEPTH     = ndrd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire ndrd_pkg::run_in_t                    in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output ndrd_pkg::run_out_t                        out_data,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ndrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ndrd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [ndrd_pkg::SPC_W-1:0]      spc_q;
	logic [ndrd_pkg::VOL_BASE_W-1:0] vol_base_q;
	logic [ndrd_pkg::ADDR_W-1:0]     dest_base_q;

	logic            push_valid, queue_full, job_valid, job_pop;
	ndrd_pkg::job_t  push_job, job;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q       <= ndrd_pkg::SPC_RESET;
			vol_base_q  <= ndrd_pkg::VOL_BASE_RESET;
			dest_base_q <= ndrd_pkg::DEST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ndrd_pkg::CFG_SPC:      spc_q       <= cfg_data[ndrd_pkg::SPC_W-1:0];
				ndrd_pkg::CFG_VOL_BASE: vol_base_q  <= cfg_data[ndrd_pkg::VOL_BASE_W-1:0];
				ndrd_pkg::CFG_DEST:     dest_base_q <= cfg_data[ndrd_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	ndrd_front #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.vol_base   (vol_base_q),
		.dest_base  (dest_base_q),
		.push_valid (push_valid),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	ndrd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (queue_full),
		.pop_valid  (job_valid),
		.pop_job    (job),
		.pop        (job_pop)
	);

	ndrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.spc        (spc_q),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

>>> verif/tb_ntfs_data_run_decoder.sv
typedef enum logic [1:0] {PH_HEADER, PH_COUNT, PH_OFFSET, PH_IDLE} parse_phase_e;

// Track the run list state and hold the results each accepted byte is due to give
class run_list_ledger;
	logic [7:0]            spc;
	logic [31:0]           vol_base;
	logic [47:0]           dest_base;
	parse_phase_e          phase;
	logic [3:0]            count_len;
	logic [3:0]            offset_len;
	logic [3:0]            byte_idx;
	logic [31:0]           count_acc;
	logic [63:0]           offset_acc;
	logic [47:0]           run_base;
	logic [47:0]           next_dest;
	ndrd_pkg::run_out_t    runs_due[$];
	int                    errors;

	function new();
		errors = 0;
		spc = ndrd_pkg::SPC_RESET;
		vol_base = ndrd_pkg::VOL_BASE_RESET;
		dest_base = ndrd_pkg::DEST_RESET;
		phase = PH_HEADER;
		count_len = '0;
		offset_len = '0;
		byte_idx = '0;
		count_acc = '0;
		offset_acc = '0;
		run_base = {16'd0, vol_base};
		next_dest = dest_base;
	endfunction

	// Registers only; base and destination reach the parse state at the next list start, spc at once
	function void write_reg(logic [ndrd_pkg::CFG_INDEX_W-1:0] idx,
			logic [ndrd_pkg::CFG_DATA_W-1:0] val);
		case (idx)
		ndrd_pkg::CFG_SPC: spc = val[7:0];
		ndrd_pkg::CFG_VOL_BASE: vol_base = val[31:0];
		ndrd_pkg::CFG_DEST: dest_base = val[47:0];
		default: ;
		endcase
	endfunction

	function int pending();
		return runs_due.size();
	endfunction

	function void push_result(logic [1:0] st, logic [47:0] ss, logic [39:0] sc,
			logic [47:0] da);
		ndrd_pkg::run_out_t r;
		r.status = st;
		r.start_sector = ss;
		r.sector_count = sc;
		r.dest_address = da;
		runs_due.push_back(r);
	endfunction

	// Sign-extend and scale the offset, advance base and destination
	function void close_run();
		logic [63:0] off;
		logic [63:0] shifted;
		logic [39:0] sectors;
		logic [47:0] dest;
		int sh;
		off = '0;
		if (offset_len >= 8) begin
			off = offset_acc;
		end else if (offset_len != 0) begin
			sh = 64 - 8 * offset_len;
			shifted = offset_acc << sh;
			off = $signed(shifted) >>> sh;
		end
		sectors = {8'd0, count_acc} * {32'd0, spc};
		dest = next_dest;
		run_base = run_base + 48'(off * {56'd0, spc});
		next_dest = next_dest + {sectors[38:0], 9'd0};
		push_result(ndrd_pkg::ST_RUN, run_base, sectors, dest);
		phase = PH_HEADER;
		byte_idx = '0;
	endfunction

	// Advance the parse on one accepted byte; report whether it was consumed
	function bit note_byte(ndrd_pkg::run_in_t it);
		logic [7:0] b;
		bit live;
		b = it.run_byte;
		live = it.list_start || (phase != PH_IDLE);
		if (it.list_start) begin
			run_base = {16'd0, vol_base};
			next_dest = dest_base;
			phase = PH_HEADER;
			byte_idx = '0;
		end
		case (phase)
		PH_HEADER: begin
			if (b == 8'd0) begin
				push_result(ndrd_pkg::ST_END, '0, '0, '0);
				phase = PH_IDLE;
			end else begin
				count_len = b[3:0];
				offset_len = b[7:4];
				if (count_len > ndrd_pkg::MAX_FIELD_BYTES_DEF ||
						offset_len > ndrd_pkg::MAX_FIELD_BYTES_DEF) begin
					push_result(ndrd_pkg::ST_MALFORMED, '0, '0, '0);
					phase = PH_IDLE;
				end else begin
					count_acc = '0;
					offset_acc = '0;
					byte_idx = '0;
					phase = (count_len != 0) ? PH_COUNT : PH_OFFSET;
				end
			end
		end
		PH_COUNT: begin
			// count bytes past the fourth are dropped
			if (byte_idx < 4)
				count_acc = count_acc | (32'(b) << (8 * byte_idx));
			byte_idx = byte_idx + 4'd1;
			if (byte_idx >= count_len) begin
				byte_idx = '0;
				if (offset_len == 0)
					close_run();
				else
					phase = PH_OFFSET;
			end
		end
		PH_OFFSET: begin
			offset_acc = offset_acc | (64'(b) << (8 * byte_idx[2:0]));
			byte_idx = byte_idx + 4'd1;
			if (byte_idx >= offset_len)
				close_run();
		end
		default: ;
		endcase
		return live;
	endfunction

	function void compare_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Match one delivered result against the oldest one due
	function void check_result(ndrd_pkg::run_out_t got);
		ndrd_pkg::run_out_t want;
		if (runs_due.size() == 0) begin
			$display("%0t: result with none due: expected none, actual status %0d start %h count %h dest %h",
				$time, got.status, got.start_sector, got.sector_count, got.dest_address);
			errors++;
			return;
		end
		want = runs_due.pop_front();
		compare_field("status", 48'(want.status), 48'(got.status));
		compare_field("start_sector", want.start_sector, got.start_sector);
		compare_field("sector_count", 48'(want.sector_count), 48'(got.sector_count));
		compare_field("dest_address", want.dest_address, got.dest_address);
	endfunction
endclass

module tb_ntfs_data_run_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import ndrd_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	run_in_t                in_data;
	logic                   out_valid;
	logic                   out_stall;
	run_out_t               out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	run_list_ledger ledger;
	bit             quiet;
	int             items_sent;

	ntfs_data_run_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Check delivered results, stall at random
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				ledger.check_result(out_data);
			@(negedge clk);
			out_stall <= !quiet && ($urandom_range(99) < 13);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	// Header with at least one length nibble above the limit
	function automatic logic [7:0] bad_header();
		logic [3:0] big;
		logic [3:0] any;
		big = 4'($urandom_range(9, 15));
		any = 4'($urandom_range(0, 15));
		return $urandom_range(1) ? {big, any} : {any, big};
	endfunction

	// Offer one item, idling beforehand at random; leave valid high once taken
	task automatic put_item(input logic [7:0] b, input logic st);
		run_in_t it;
		it.run_byte = b;
		it.list_start = st;
		while (!quiet && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (ledger.note_byte(it))
			items_sent++;
		@(negedge clk);
	endtask

	// Send a header and up to keep of its field bytes
	task automatic send_run(input logic [3:0] clen, input logic [3:0] olen,
			input logic [63:0] cval, input logic [63:0] oval, input bit first,
			input int keep);
		put_item({olen, clen}, first);
		for (int i = 0; i < clen && i < keep; i++)
			put_item(cval[8*i +: 8], 1'b0);
		for (int i = 0; i < olen && clen + i < keep; i++)
			put_item(oval[8*i +: 8], 1'b0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ledger.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_config(input logic [7:0] spc, input logic [31:0] vol,
			input logic [47:0] dest);
		write_reg(CFG_SPC, CFG_DATA_W'(spc));
		write_reg(CFG_VOL_BASE, CFG_DATA_W'(vol));
		write_reg(CFG_DEST, CFG_DATA_W'(dest));
		cfg_valid <= 1'b0;
	endtask

	// Drain every due result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic directed_checks();
		// negative one-byte offset
		send_run(4'd1, 4'd1, 64'hFF, 64'h80, 1'b1, 2);
		// zero count, no offset bytes
		send_run(4'd1, 4'd0, 64'h00, 64'h0, 1'b0, 1);
		// no count bytes, offset of minus one
		send_run(4'd0, 4'd2, 64'h0, 64'hFFFF, 1'b0, 2);
		// eight count bytes, upper four dropped
		send_run(4'd8, 4'd1, '1, 64'h7F, 1'b0, 9);
		// end of list, then a byte ignored while idle
		put_item(8'h00, 1'b0);
		put_item(8'h55, 1'b0);
		// count length too large, then offset length too large
		put_item(8'h89, 1'b1);
		put_item(8'hF1, 1'b1);
		// run cut short by a new, empty list
		send_run(4'd2, 4'd1, 64'hAA, 64'h0, 1'b1, 1);
		put_item(8'h00, 1'b1);
	endtask

	// Mostly well-formed lists with random content; some broken or cut short
	task automatic random_lists(input int target);
		int runs;
		int ending;
		int clen;
		int olen;
		int keep;
		while (items_sent < target) begin
			runs = $urandom_range(0, 6);
			ending = $urandom_range(99);
			for (int r = 0; r < runs; r++) begin
				clen = $urandom_range(0, 8);
				olen = $urandom_range(0, 8);
				if ($urandom_range(3) == 0) begin
					clen = $urandom_range(0, 2);
					olen = $urandom_range(0, 2);
				end
				if (clen == 0 && olen == 0)
					clen = 1;
				keep = clen + olen;
				if (r == runs - 1 && ending >= 85)
					keep = $urandom_range(0, clen + olen);
				send_run(4'(clen), 4'(olen), rand64(), rand64(), r == 0, keep);
			end
			if (ending < 75)
				put_item(8'h00, runs == 0);
			else if (ending < 85)
				put_item(bad_header(), runs == 0);
			// trailing noise, ignored while idle
			if (ending < 85)
				repeat ($urandom_range(0, 2)) put_item(8'($urandom), 1'b0);
		end
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SPC;
		cfg_data = '0;
		quiet = 1'b0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_checks();
		for (int p = 0; p < 8; p++) begin
			// reconfigure only once the block has gone quiet
			if (p > 0) begin
				settle();
				case (p)
				1: write_config(8'd1, 32'd0, 48'd0);
				2: write_config(8'd255, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
				3: write_config(8'd0, $urandom, rand48());
				default: write_config(8'($urandom_range(1, 255)), $urandom, rand48());
				endcase
			end
			quiet = (p == 2);
			random_lists(items_sent + 166);
		end
		settle();

		if (ledger.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> ntfs_data_run_decoder.f
src/ndrd_pkg.sv
src/ndrd_front.sv
src/ndrd_fifo.sv
src/ndrd_back.sv
src/ntfs_data_run_decoder.sv
verif/tb_ntfs_data_run_decoder.sv
